// ===== rtl/jcce_pkg.sv =====
package jcce_pkg;

    // Cable command byte bits.
    localparam logic [7:0] PIN_TCK         = 8'h01;
    localparam logic [7:0] PIN_TMS         = 8'h02;
    localparam logic [7:0] PIN_TDI         = 8'h10;
    localparam logic [7:0] PIN_OE          = 8'h20;
    localparam logic [7:0] FLAG_READ       = 8'h40;
    localparam logic [7:0] FLAG_BYTE_SHIFT = 8'h80;

    // Result kinds on the output stream.
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_TDO     = 1'b1;

    // Which word the datapath loads into the output register.
    typedef enum logic [2:0] {
        SEL_HDR   = 3'd0,
        SEL_DATA  = 3'd1,
        SEL_BIT   = 3'd2,
        SEL_BANG  = 3'd3,
        SEL_REPLY = 3'd4
    } t_sel;

    typedef struct packed {
        logic accept;
        logic emit;
        t_sel sel;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic can_emit;
        logic is_reply;
        logic buffered;
        logic scan_end;
        logic full;
        logic has_whole;
        logic has_left;
        logic bang;
        logic data_last;
        logic bit_last;
        logic phase;
    } t_dp_sts;

endpackage

// ===== rtl/jtag_cable_command_encoder.sv =====
// Each item is accepted in the idle state and evaluated in the next state; then
// its output words are loaded into the output register one after another.
// The first word reaches the output register from the emit state that follows evaluation.
// Words leave at one per cycle while the receiver is ready, set by the single output register.
// i_rst_n is synchronous and empties the shift buffer at once; no clearing pass.
module jtag_cable_command_encoder
    import jcce_pkg::*;
#(
    parameter int MAX_SHIFT_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // tms_level, tdi_level, want_tdo, reply_byte[7:0], zeros
    input  logic [0:0]  i_s_axis_tuser,  // cmd
    input  logic        i_s_axis_tlast,  // scan_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // command_byte[7:0], tdo_value, zeros
    output logic [0:0]  o_m_axis_tuser,  // kind
    output logic        o_m_axis_tlast   // last_of_run
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    jcce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(i_s_axis_tvalid),
        .o_s_ready(o_s_axis_tready),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd)
    );

    jcce_dp #(
        .MAX_SHIFT_BYTES(MAX_SHIFT_BYTES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .i_s_tdata (i_s_axis_tdata),
        .i_s_tuser (i_s_axis_tuser[0]),
        .i_s_tlast (i_s_axis_tlast),
        .o_m_tvalid(o_m_axis_tvalid),
        .i_m_tready(i_m_axis_tready),
        .o_m_tdata (o_m_axis_tdata),
        .o_m_tuser (o_m_axis_tuser[0]),
        .o_m_tlast (o_m_axis_tlast)
    );

endmodule

// ===== rtl/jcce_ram.sv =====
module jcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/jcce_ctrl.sv =====
module jcce_ctrl
    import jcce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EVAL  = 7'b0000010,
        ST_HDR   = 7'b0000100,
        ST_DATA  = 7'b0001000,
        ST_BITS  = 7'b0010000,
        ST_BANG  = 7'b0100000,
        ST_REPLY = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.emit   = 1'b0;
        o_cmd.sel    = SEL_HDR;
        o_cmd.clear  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.is_reply) begin
                    n_state = ST_REPLY;
                end else if (i_sts.buffered && !i_sts.full && !i_sts.scan_end) begin
                    n_state = ST_IDLE;
                end else if (i_sts.has_whole) begin
                    n_state = ST_HDR;
                end else if (i_sts.has_left) begin
                    n_state = ST_BITS;
                end else if (i_sts.bang) begin
                    n_state = ST_BANG;
                end else begin
                    // Flush of an empty buffer with nothing to send.
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_HDR: begin
                o_cmd.sel = SEL_HDR;
                if (i_sts.can_emit) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_DATA;
                end
            end
            ST_DATA: begin
                o_cmd.sel = SEL_DATA;
                if (i_sts.can_emit) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.data_last) begin
                        if (i_sts.has_left) begin
                            n_state = ST_BITS;
                        end else if (i_sts.bang) begin
                            n_state = ST_BANG;
                        end else begin
                            o_cmd.clear = 1'b1;
                            n_state     = ST_IDLE;
                        end
                    end
                end
            end
            ST_BITS: begin
                o_cmd.sel = SEL_BIT;
                if (i_sts.can_emit) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.phase && i_sts.bit_last) begin
                        if (i_sts.bang) begin
                            n_state = ST_BANG;
                        end else begin
                            o_cmd.clear = 1'b1;
                            n_state     = ST_IDLE;
                        end
                    end
                end
            end
            ST_BANG: begin
                o_cmd.sel = SEL_BANG;
                if (i_sts.can_emit) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.phase) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_REPLY: begin
                o_cmd.sel = SEL_REPLY;
                if (i_sts.can_emit) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/jcce_dp.sv =====
module jcce_dp
    import jcce_pkg::*;
#(
    parameter int MAX_SHIFT_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    localparam int CW = $clog2(MAX_SHIFT_BYTES * 8 + 1);
    localparam int WW = CW - 3;
    localparam int IW = (MAX_SHIFT_BYTES > 1) ? $clog2(MAX_SHIFT_BYTES) : 1;
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_SHIFT_BYTES * 8);

    // Buffer of pending shift cycles: whole bytes in the RAM, partial byte here.
    logic [CW-1:0] r_cnt;
    logic [7:0]    r_acc;
    logic [7:0]    n_acc;

    // Latched item.
    logic r_cmd, r_tms, r_tdi, r_rd, r_end, r_tdo;

    // Flush sequencing.
    logic [IW-1:0] r_rptr;
    logic [WW-1:0] r_sent;
    logic [2:0]    r_bit;
    logic          r_ph;

    // Output register.
    logic       r_ovalid;
    logic       r_kind;
    logic [7:0] r_byte;
    logic       r_otdo;
    logic       r_last;

    logic       in_buf;
    logic       ram_we;
    logic       ram_re;
    logic [7:0] ram_rdata;
    logic [WW-1:0] whole;
    logic [2:0] left;
    logic       bang;
    logic       data_last;
    logic       bit_last;
    logic       can_emit;
    logic [7:0] bit_pins;
    logic [7:0] bang_pins;
    logic [7:0] e_byte;
    logic       e_last;

    assign in_buf = !i_s_tuser && !i_s_tdata[0] && !i_s_tdata[2];
    assign n_acc  = r_acc | (i_s_tdata[1] ? (8'h01 << r_cnt[2:0]) : 8'h00);
    assign ram_we = i_cmd.accept && in_buf && (r_cnt[2:0] == 3'd7);

    assign whole     = r_cnt[CW-1:3];
    assign left      = r_cnt[2:0];
    assign bang      = !r_cmd && (r_tms || r_rd);
    assign data_last = (r_sent == (whole - WW'(1)));
    assign bit_last  = (r_bit == (left - 3'd1));
    assign can_emit  = !r_ovalid || i_m_tready;

    assign ram_re = i_cmd.emit && ((i_cmd.sel == SEL_HDR) ||
                    ((i_cmd.sel == SEL_DATA) && !data_last));

    jcce_ram #(
        .WIDTH(8),
        .DEPTH(MAX_SHIFT_BYTES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_cnt[3 +: IW]),
        .i_wdata(n_acc),
        .i_re   (ram_re),
        .i_raddr(r_rptr),
        .o_rdata(ram_rdata)
    );

    assign bit_pins  = PIN_OE | (r_acc[r_bit] ? PIN_TDI : 8'h00);
    assign bang_pins = PIN_OE | (r_tms ? PIN_TMS : 8'h00) | (r_tdi ? PIN_TDI : 8'h00);

    always_comb begin
        e_byte = 8'h00;
        e_last = 1'b0;
        case (i_cmd.sel)
            SEL_HDR: begin
                e_byte = FLAG_BYTE_SHIFT | 8'(whole);
            end
            SEL_DATA: begin
                e_byte = ram_rdata;
                e_last = data_last && (left == 3'd0) && !bang;
            end
            SEL_BIT: begin
                e_byte = r_ph ? (bit_pins | PIN_TCK) : bit_pins;
                e_last = r_ph && bit_last && !bang;
            end
            SEL_BANG: begin
                e_byte = r_ph ? (bang_pins | PIN_TCK) : (bang_pins | (r_rd ? FLAG_READ : 8'h00));
                e_last = r_ph;
            end
            SEL_REPLY: begin
                e_last = 1'b1;
            end
            default: begin
                e_byte = 8'h00;
                e_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_acc    <= '0;
            r_rptr   <= '0;
            r_sent   <= '0;
            r_bit    <= '0;
            r_ph     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.accept && in_buf) begin
                r_cnt <= r_cnt + CW'(1);
                r_acc <= (r_cnt[2:0] == 3'd7) ? 8'h00 : n_acc;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (ram_re) begin
                r_rptr <= r_rptr + IW'(1);
            end
            if (i_cmd.emit && (i_cmd.sel == SEL_DATA)) begin
                r_sent <= r_sent + WW'(1);
            end
            if (i_cmd.emit && ((i_cmd.sel == SEL_BIT) || (i_cmd.sel == SEL_BANG))) begin
                r_ph <= !r_ph;
                if ((i_cmd.sel == SEL_BIT) && r_ph) begin
                    r_bit <= r_bit + 3'd1;
                end
            end
            if (i_cmd.clear) begin
                r_cnt  <= '0;
                r_acc  <= '0;
                r_rptr <= '0;
                r_sent <= '0;
                r_bit  <= '0;
                r_ph   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_s_tuser;
            r_tms <= i_s_tdata[0];
            r_tdi <= i_s_tdata[1];
            r_rd  <= i_s_tdata[2];
            r_tdo <= i_s_tdata[3];
            r_end <= i_s_tlast;
        end
        if (i_cmd.emit) begin
            r_kind <= (i_cmd.sel == SEL_REPLY) ? KIND_TDO : KIND_COMMAND;
            r_byte <= e_byte;
            r_otdo <= (i_cmd.sel == SEL_REPLY) ? r_tdo : 1'b0;
            r_last <= e_last;
        end
    end

    assign o_sts.can_emit  = can_emit;
    assign o_sts.is_reply  = r_cmd;
    assign o_sts.buffered  = !r_cmd && !r_tms && !r_rd;
    assign o_sts.scan_end  = r_end;
    assign o_sts.full      = (r_cnt == FULL_COUNT);
    assign o_sts.has_whole = (whole != '0);
    assign o_sts.has_left  = (left != 3'd0);
    assign o_sts.bang      = bang;
    assign o_sts.data_last = data_last;
    assign o_sts.bit_last  = bit_last;
    assign o_sts.phase     = r_ph;

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'd0, r_otdo, r_byte};
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;

endmodule

// ===== dv/cable_stream_checker.sv =====
`timescale 1ns / 1ps

module cable_stream_checker
    import jcce_pkg::*;
#(
    parameter int MAX_SHIFT_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // tms_level, tdi_level, want_tdo, reply_byte[7:0], zeros
    input  logic [0:0]  i_s_tuser,   // cmd
    input  logic        i_s_tlast,   // scan_end
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,   // command_byte[7:0], tdo_value, zeros
    input  logic [0:0]  i_m_tuser,   // kind
    input  logic        i_m_tlast,   // last_of_run
    output int          o_errors,
    output int          o_outstanding
);

    typedef struct packed {
        logic       kind;
        logic [7:0] cmd_byte;
        logic       tdo;
        logic       last;
    } t_cable_word;

    t_cable_word expected_words[$];

    logic [7:0] tdi_buf [MAX_SHIFT_BYTES];
    logic [8:0] buf_bits;
    int         err_count = 0;

    task automatic report(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    function automatic void queue_word(logic kind, logic [7:0] cmd_byte, logic tdo);
        t_cable_word w;
        w = '{kind, cmd_byte, tdo, 1'b0};
        expected_words = {expected_words, w};
    endfunction

    function automatic void queue_bang(logic tms, logic tdi, logic rd);
        logic [7:0] pins;
        pins = PIN_OE | (tms ? PIN_TMS : 8'h00) | (tdi ? PIN_TDI : 8'h00);
        queue_word(KIND_COMMAND, pins | (rd ? FLAG_READ : 8'h00), 1'b0);
        queue_word(KIND_COMMAND, pins | PIN_TCK, 1'b0);
    endfunction

    // Whole buffered bytes go under one byte-shift header; the partial byte moves to slot 0.
    function automatic void ship_whole_bytes();
        int whole;
        int i;
        whole = int'(buf_bits >> 3);
        if (whole == 0) return;
        if (whole > MAX_SHIFT_BYTES) whole = MAX_SHIFT_BYTES;
        queue_word(KIND_COMMAND, FLAG_BYTE_SHIFT | 8'(whole), 1'b0);
        for (i = 0; i < whole; i++) queue_word(KIND_COMMAND, tdi_buf[i], 1'b0);
        tdi_buf[0] = (whole < MAX_SHIFT_BYTES) ? tdi_buf[whole] : 8'h00;
        for (i = 1; i < MAX_SHIFT_BYTES; i++) tdi_buf[i] = 8'h00;
        buf_bits = buf_bits - 9'(whole * 8);
    endfunction

    function automatic void flush_buffer();
        int i;
        ship_whole_bytes();
        for (i = 0; i < int'(buf_bits) && i < 8; i++) queue_bang(1'b0, tdi_buf[0][i], 1'b0);
        for (i = 0; i < MAX_SHIFT_BYTES; i++) tdi_buf[i] = 8'h00;
        buf_bits = '0;
    endfunction

    function automatic void predict_word(logic [15:0] data, logic cmd, logic scan_end);
        logic       tms;
        logic       tdi;
        logic       rd;
        int         first;
        int         slot;
        tms   = data[0];
        tdi   = data[1];
        rd    = data[2];
        first = expected_words.size();
        if (cmd) begin
            queue_word(KIND_TDO, 8'h00, data[3]);
        end else if (!tms && !rd) begin
            slot = int'(buf_bits >> 3);
            if (slot < MAX_SHIFT_BYTES) begin
                if (tdi) tdi_buf[slot][buf_bits[2:0]] = 1'b1;
                buf_bits = buf_bits + 9'd1;
            end
            if (int'(buf_bits) >= MAX_SHIFT_BYTES * 8) ship_whole_bytes();
            if (scan_end) flush_buffer();
        end else begin
            flush_buffer();
            queue_bang(tms, tdi, rd);
        end
        if (expected_words.size() > first)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_cable_word want;
        if (!i_rst_n) begin
            expected_words.delete();
            for (int i = 0; i < MAX_SHIFT_BYTES; i++) tdi_buf[i] = 8'h00;
            buf_bits = '0;
        end else begin
            if (i_s_tvalid && i_s_tready) predict_word(i_s_tdata, i_s_tuser[0], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_words.size() == 0) begin
                    report("unexpected word, tdata", i_m_tdata, 0);
                end else begin
                    want = expected_words.pop_front();
                    if (i_m_tuser[0] !== want.kind) report("kind", i_m_tuser[0], want.kind);
                    if (i_m_tdata[7:0] !== want.cmd_byte)
                        report("command byte", i_m_tdata[7:0], want.cmd_byte);
                    if (i_m_tdata[8] !== want.tdo) report("tdo value", i_m_tdata[8], want.tdo);
                    if (i_m_tdata[15:9] !== 7'd0) report("tdata padding", i_m_tdata[15:9], 0);
                    if (i_m_tlast !== want.last) report("last of run", i_m_tlast, want.last);
                end
            end
        end
        o_errors      <= err_count;
        o_outstanding <= expected_words.size();
    end

endmodule

// ===== dv/tb_jtag_cable_command_encoder.sv =====
`timescale 1ns / 1ps

module tb_jtag_cable_command_encoder;

    localparam int MAX_SHIFT_BYTES = 32;
    localparam int ITEMS           = 470;
    localparam int CYCLE_LIMIT     = 5_000_000;
    localparam int HOLD_CYCLES     = 300;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    int   errors;
    int   outstanding;
    int   items_sent = 0;
    int   cycle_count = 0;
    logic no_gaps = 1'b0;
    logic hold_request = 1'b0;

    jtag_cable_command_encoder #(
        .MAX_SHIFT_BYTES(MAX_SHIFT_BYTES)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    cable_stream_checker #(
        .MAX_SHIFT_BYTES(MAX_SHIFT_BYTES)
    ) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_errors     (errors),
        .o_outstanding(outstanding)
    );

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_jtag_cable_command_encoder: errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Receiver: ready runs broken by stalls, plus one long hold-off on request.
    initial begin
        int   run;
        int   stall;
        logic hold_done;
        run       = 0;
        stall     = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else if (run > 0) begin
                m_tready = 1'b1;
                run--;
            end else if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 20);
                stall = pick_gap();
                if (stall > 30) stall = $urandom_range(10, 30);
            end
        end
    end

    // Each call starts and ends at a falling edge; tvalid stays high across back-to-back words.
    task automatic drive_word(input logic cmd, input logic tms, input logic tdi,
                              input logic rd, input logic scan_end, input logic [7:0] reply);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tlast  = scan_end;
        s_tdata  = {5'b0, reply, rd, tdi, tms};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_cycle(input logic tms, input logic tdi, input logic rd,
                              input logic scan_end);
        drive_word(1'b0, tms, tdi, rd, scan_end, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_reply(input logic [7:0] reply);
        drive_word(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), reply);
    endtask

    // A data scan; read scans are followed by the cable's reply bytes.
    task automatic run_scan(input int len, input logic rd, input logic allow_flip);
        int   reads;
        logic r;
        logic last;
        reads = 0;
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            r = rd;
            if (allow_flip && $urandom_range(0, 19) == 0) r = ~rd;
            send_cycle(last && $urandom_range(0, 1), 1'($urandom_range(0, 1)), r, last);
            if (r) reads++;
        end
        for (int i = 0; i < reads; i++) send_reply(8'($urandom_range(0, 255)));
    endtask

    // The last word was already taken, so stop offering it before waiting.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    initial begin
        logic long_done;
        logic pressure_done;
        int   pick;
        long_done     = 1'b0;
        pressure_done = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reply extremes, then bit-banged cycles with and without a read.
        send_reply(8'h00);
        send_reply(8'hFF);
        send_reply(8'hFE);
        send_cycle(1'b1, 1'b1, 1'b1, 1'b1);
        send_cycle(1'b1, 1'b0, 1'b0, 1'b0);
        send_cycle(1'b0, 1'b1, 1'b1, 1'b0);
        // Buffered cycles ended by a buffered scan end.
        send_cycle(1'b0, 1'b1, 1'b0, 1'b0);
        send_cycle(1'b0, 1'b0, 1'b0, 1'b0);
        send_cycle(1'b0, 1'b1, 1'b0, 1'b0);
        send_cycle(1'b0, 1'b1, 1'b0, 1'b1);
        // A whole byte plus leftovers, flushed by a TMS-high cycle.
        for (int i = 0; i < 10; i++) send_cycle(1'b0, 1'(i % 2), 1'b0, 1'b0);
        send_cycle(1'b1, 1'b1, 1'b0, 1'b1);
        send_cycle(1'b0, 1'b0, 1'b0, 1'b1);
        // Readback switched on only for the word that ends the scan.
        send_cycle(1'b0, 1'b1, 1'b0, 1'b0);
        send_cycle(1'b0, 1'b0, 1'b0, 1'b0);
        send_cycle(1'b0, 1'b1, 1'b1, 1'b1);
        wait_drained();

        items_sent = 0;
        while (items_sent < ITEMS) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 9);
            if (!long_done && items_sent > 60) begin
                // Long enough to fill the buffer and force a shift on its own.
                long_done = 1'b1;
                run_scan($urandom_range(256, 263), 1'b0, 1'b0);
            end else if (!pressure_done && items_sent > 150) begin
                pressure_done = 1'b1;
                no_gaps = 1'b1;
                hold_request = 1'b1;
                repeat (30) send_cycle(1'b1, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                wait_drained();
            end else if (pick < 1) begin
                repeat ($urandom_range(1, 6))
                    drive_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end else if (pick < 3) begin
                repeat ($urandom_range(1, 6))
                    send_cycle($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
            end else if ($urandom_range(0, 2) == 0) begin
                run_scan($urandom_range(1, 16), 1'b1, 1'b1);
            end else begin
                run_scan($urandom_range(1, 40), 1'b0, 1'b1);
            end
        end
        s_tvalid = 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && outstanding == 0) begin
            $display("tb_jtag_cable_command_encoder: clean");
        end else begin
            $display("tb_jtag_cable_command_encoder: errors");
        end
        $finish;
    end

endmodule

// ===== jtag_cable_command_encoder.f =====
rtl/jcce_pkg.sv
rtl/jcce_ram.sv
rtl/jcce_ctrl.sv
rtl/jcce_dp.sv
rtl/jtag_cable_command_encoder.sv
dv/cable_stream_checker.sv
dv/tb_jtag_cable_command_encoder.sv
